// ----- design/jlp_pkg.sv -----
// ----------------------------------------------------------------------------
// jlp_pkg
// Shared types and constants for the JSON line prefilter.
// ----------------------------------------------------------------------------
package jlp_pkg;

  // Configuration port geometry: one 32-bit register, word aligned.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // Register word index of the nesting limit.
  localparam logic [ADDR_W-3:0] REG_MAX_DEPTH = '0;

  // Nesting limit after reset.
  localparam logic [7:0] MAX_DEPTH_RESET = 8'd64;

  // Verdict codes given once per line.
  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_EMPTY    = 3'd1,
    VERDICT_BOM      = 3'd2,
    VERDICT_BAD_UTF8 = 3'd3,
    VERDICT_TOO_DEEP = 3'd4
  } verdict_e;

  // Per-item control from the top level to the checking units.
  typedef struct packed {
    logic step;   // a present byte is being processed
    logic clear;  // the line ends with this item
  } step_ctl_t;

  // Byte order mark, expected byte for each of the first three positions.
  function automatic logic [7:0] bom_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = 8'hEF;
      2'd1:    val = 8'hBB;
      2'd2:    val = 8'hBF;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ----- design/json_line_prefilter.sv -----
// ----------------------------------------------------------------------------
// json_line_prefilter
// Screens request lines for emptiness, a byte order mark, bad UTF-8 and
// excessive JSON nesting, giving one verdict per line.
// ----------------------------------------------------------------------------
// The block takes one byte item per clock cycle while in_stall_o is low.
// Each accepted item is held in an input register until it can move on,
// then the UTF-8 decoder, the bracket counter and the byte order mark match
// update in a single pass, and when the line's last item leaves the input
// register the verdict is loaded into the result register, which drives the
// output. Input stall rises only while a verdict waits in the result register
// under output stall and the next line end is already held in the input
// register. The nesting limit is written through the APB port at address 0;
// the user must do so only while no line is open, the block does not enforce it.
module json_line_prefilter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jlp_pkg::ADDR_W-1:0]  paddr,
  input  logic [jlp_pkg::DATA_W-1:0]  pwdata,
  output logic [jlp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // Byte items in
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        byte_present_i,
  input  logic                        end_of_line_i,
  // Verdict items out
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  verdict_o
);
  import jlp_pkg::*;

  logic       cfg_wr;
  logic [7:0] max_depth_q;
  logic       reg_sel;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       present_q;
  logic       eol_q;
  logic       advance;

  step_ctl_t  ctl;
  logic       utf8_bad;
  logic       too_deep;

  logic [1:0] pos_q, pos_d;
  logic       bom_q, bom_d;
  logic       nonempty_q, nonempty_d;
  verdict_e   verdict;

  logic       out_valid_q;
  verdict_e   verdict_q;

  // Configuration register.
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_MAX_DEPTH);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DATA_W-8){1'b0}}, max_depth_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_depth_q <= MAX_DEPTH_RESET;
    end else if (cfg_wr) begin
      max_depth_q <= pwdata[7:0];
    end
  end

  // The held item moves on unless it ends a line while a verdict waits under output stall.
  assign advance    = in_valid_q && (!eol_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q    <= data_byte_i;
      present_q <= byte_present_i;
      eol_q     <= end_of_line_i;
    end
  end

  assign ctl.step  = advance && present_q;
  assign ctl.clear = advance && eol_q;

  // Checking units.
  jlp_utf8 u_utf8 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .byte_i (byte_q),
    .bad_o  (utf8_bad)
  );

  jlp_depth u_depth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .byte_i      (byte_q),
    .max_depth_i (max_depth_q),
    .too_deep_o  (too_deep)
  );

  // Byte order mark match over the first three bytes, and line presence.
  always_comb begin
    pos_d      = pos_q;
    bom_d      = bom_q;
    nonempty_d = nonempty_q;
    if (ctl.step) begin
      nonempty_d = 1'b1;
      if (pos_q != 2'd3) begin
        if (byte_q != bom_byte(pos_q)) begin
          bom_d = 1'b0;
        end
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 2'd0;
      bom_q      <= 1'b1;
      nonempty_q <= 1'b0;
    end else if (ctl.clear) begin
      pos_q      <= 2'd0;
      bom_q      <= 1'b1;
      nonempty_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      bom_q      <= bom_d;
      nonempty_q <= nonempty_d;
    end
  end

  // Verdict in priority order.
  always_comb begin
    if (!nonempty_d) begin
      verdict = VERDICT_EMPTY;
    end else if ((pos_d == 2'd3) && bom_d) begin
      verdict = VERDICT_BOM;
    end else if (utf8_bad) begin
      verdict = VERDICT_BAD_UTF8;
    end else if (too_deep) begin
      verdict = VERDICT_TOO_DEEP;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.clear) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.clear) begin
      verdict_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ----- design/jlp_utf8.sv -----
// ----------------------------------------------------------------------------
// jlp_utf8
// Strict UTF-8 checker: decodes multi-byte sequences and flags bad forms.
// ----------------------------------------------------------------------------
module jlp_utf8 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jlp_pkg::step_ctl_t ctl_i,
  input  logic [7:0]         byte_i,
  output logic               bad_o
);
  import jlp_pkg::*;

  // Least code point class of the sequence being assembled.
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_TWO  = 2'd1,
    CLS_THREE = 2'd2,
    CLS_FOUR = 2'd3
  } cp_class_e;

  logic [1:0]  cont_q, cont_d;
  logic [20:0] acc_q, acc_d;
  cp_class_e   cls_q, cls_d;
  logic        bad_q, bad_d;
  logic [20:0] least;

  // Smallest legal code point for the current sequence length.
  always_comb begin
    case (cls_q)
      CLS_TWO:   least = 21'h00080;
      CLS_THREE: least = 21'h00800;
      default:   least = 21'h10000;
    endcase
  end

  // Next decoder state for one byte.
  always_comb begin
    cont_d = cont_q;
    acc_d  = acc_q;
    cls_d  = cls_q;
    bad_d  = bad_q;
    if (ctl_i.step && !bad_q) begin
      if (cont_q == 2'd0) begin
        if (byte_i[7] == 1'b0) begin
          // Plain ASCII leaves the decoder untouched.
        end else if (byte_i[7:5] == 3'b110) begin
          cont_d = 2'd1;
          acc_d  = {16'd0, byte_i[4:0]};
          cls_d  = CLS_TWO;
        end else if (byte_i[7:4] == 4'b1110) begin
          cont_d = 2'd2;
          acc_d  = {17'd0, byte_i[3:0]};
          cls_d  = CLS_THREE;
        end else if (byte_i[7:3] == 5'b11110) begin
          cont_d = 2'd3;
          acc_d  = {18'd0, byte_i[2:0]};
          cls_d  = CLS_FOUR;
        end else begin
          bad_d = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        bad_d  = 1'b1;
        cont_d = 2'd0;
      end else begin
        acc_d  = {acc_q[14:0], byte_i[5:0]};
        cont_d = cont_q - 2'd1;
        // Last continuation: reject overlong forms, surrogates and
        // code points past the Unicode range.
        if (cont_d == 2'd0) begin
          if ((acc_d < least) || (acc_d > 21'h10FFFF) ||
              ((acc_d >= 21'h00D800) && (acc_d <= 21'h00DFFF))) begin
            bad_d = 1'b1;
          end
        end
      end
    end
  end

  // A cut-off sequence at the end of the line also counts as bad.
  assign bad_o = bad_d || (cont_d != 2'd0);

  // Decoder state; cleared when the line ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q <= 2'd0;
      acc_q  <= '0;
      cls_q  <= CLS_NONE;
      bad_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      cont_q <= 2'd0;
      acc_q  <= '0;
      cls_q  <= CLS_NONE;
      bad_q  <= 1'b0;
    end else begin
      cont_q <= cont_d;
      acc_q  <= acc_d;
      cls_q  <= cls_d;
      bad_q  <= bad_d;
    end
  end

endmodule

// ----- design/jlp_depth.sv -----
// ----------------------------------------------------------------------------
// jlp_depth
// JSON nesting tracker: counts brackets outside strings against a limit.
// ----------------------------------------------------------------------------
module jlp_depth (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jlp_pkg::step_ctl_t ctl_i,
  input  logic [7:0]         byte_i,
  input  logic [7:0]         max_depth_i,
  output logic               too_deep_o
);
  import jlp_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  logic       str_q, str_d;
  logic       esc_q, esc_d;
  logic [8:0] level_q, level_d;
  logic       deep_q, deep_d;
  logic [8:0] limit;

  assign limit = {1'b0, max_depth_i};

  // Next string and nesting state for one byte.
  always_comb begin
    str_d   = str_q;
    esc_d   = esc_q;
    level_d = level_q;
    deep_d  = deep_q;
    if (ctl_i.step) begin
      if (str_q) begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (byte_i == CH_BSLASH) begin
          esc_d = 1'b1;
        end else if (byte_i == CH_QUOTE) begin
          str_d = 1'b0;
        end
      end else if (byte_i == CH_QUOTE) begin
        str_d = 1'b1;
      end else if ((byte_i == CH_LBRACE) || (byte_i == CH_LBRACK)) begin
        // The level stops one past the limit.
        if (level_q <= limit) begin
          level_d = level_q + 9'd1;
        end
        if (level_d > limit) begin
          deep_d = 1'b1;
        end
      end else if (((byte_i == CH_RBRACE) || (byte_i == CH_RBRACK)) &&
                   (level_q != 9'd0)) begin
        level_d = level_q - 9'd1;
      end
    end
  end

  assign too_deep_o = deep_d;

  // Tracker state; cleared when the line ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q   <= 1'b0;
      esc_q   <= 1'b0;
      level_q <= '0;
      deep_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      str_q   <= 1'b0;
      esc_q   <= 1'b0;
      level_q <= '0;
      deep_q  <= 1'b0;
    end else begin
      str_q   <= str_d;
      esc_q   <= esc_d;
      level_q <= level_d;
      deep_q  <= deep_d;
    end
  end

endmodule

// ----- design/jlp_checker.sv -----
// ----------------------------------------------------------------------------
// jlp_checker
// Port-level checks on the JSON line prefilter, bound to the top level.
// ----------------------------------------------------------------------------
module jlp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [jlp_pkg::ADDR_W-1:0]  paddr,
  input logic [jlp_pkg::DATA_W-1:0]  pwdata,
  input logic [jlp_pkg::DATA_W-1:0]  prdata,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [2:0]                  verdict_o
);
  import jlp_pkg::*;

  // A waiting verdict holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o))
    else $error("verdict changed while stalled");

  // Only defined verdict codes leave the block.
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o <= VERDICT_TOO_DEEP))
    else $error("undefined verdict code");

  // Input is never held off while the result side is empty.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no verdict waiting");

  // A write of the nesting limit reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_MAX_DEPTH)
      ##1 (paddr == $past(paddr))
      |-> (prdata[7:0] == $past(pwdata[7:0])) && (prdata[DATA_W-1:8] == '0))
    else $error("nesting limit readback differs from the written value");

endmodule

bind json_line_prefilter jlp_checker u_jlp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o)
);

// ----- tb/json_line_prefilter_tb.sv -----
// ----------------------------------------------------------------------------
// json_line_prefilter_tb
// Self-checking testbench for the JSON line prefilter. Byte items are driven
// through the valid/stall channel and verdicts are collected on the output
// channel. A cycle-free predictor tracks the line state and computes the
// expected verdict, which is compared with each verdict the block returns.
// Directed lines cover line framing, the byte order mark, the UTF-8 rules and
// the nesting rules. Random lines then run under several nesting limits,
// with random input gaps and output stalls in all but the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_line_prefilter_tb;
  import jlp_pkg::*;

  // Characters that matter to the nesting check.
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;

  // Byte order mark.
  localparam logic [7:0] BOM_0 = 8'hEF;
  localparam logic [7:0] BOM_1 = 8'hBB;
  localparam logic [7:0] BOM_2 = 8'hBF;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 190;

  typedef logic [7:0] line_t [$];

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                byte_present_i;
  logic                end_of_line_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          verdict_o;

  // Predictor state for the line in progress.
  logic [1:0]          u8_cont_left;
  logic [20:0]         u8_cp;
  logic [1:0]          u8_class;
  logic                u8_bad;
  logic                str_open;
  logic                str_escape;
  logic [8:0]          nest;
  logic                nest_over;
  logic [1:0]          bom_pos;
  logic                bom_ok;
  logic                seen_byte;
  logic [7:0]          depth_limit;

  verdict_e            verdicts_due [$];
  int unsigned         items_taken;
  int unsigned         mismatch_count;
  bit                  steady_flow;

  json_line_prefilter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .end_of_line_i  (end_of_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_line_state();
    u8_cont_left = '0;
    u8_cp        = '0;
    u8_class     = '0;
    u8_bad       = 1'b0;
    str_open     = 1'b0;
    str_escape   = 1'b0;
    nest         = '0;
    nest_over    = 1'b0;
    bom_pos      = '0;
    bom_ok       = 1'b1;
    seen_byte    = 1'b0;
  endtask

  // Advances the line state by one accepted item and, at a line end, queues
  // the verdict that the block must return.
  task automatic predict_verdict(input logic [7:0] b, input logic pres, input logic eol);
    logic [20:0] least;
    verdict_e    v;
    if (pres) begin
      seen_byte = 1'b1;

      // The first three bytes are matched against the byte order mark.
      if (bom_pos != 2'd3) begin
        case (bom_pos)
          2'd0:    if (b != BOM_0) bom_ok = 1'b0;
          2'd1:    if (b != BOM_1) bom_ok = 1'b0;
          default: if (b != BOM_2) bom_ok = 1'b0;
        endcase
        bom_pos = bom_pos + 2'd1;
      end

      // Strict UTF-8 decoding; the first error freezes the decoder.
      if (!u8_bad) begin
        if (u8_cont_left == 2'd0) begin
          if (b[7]) begin
            if (b[7:5] == 3'b110) begin
              u8_cont_left = 2'd1;
              u8_cp        = {16'd0, b[4:0]};
              u8_class     = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
              u8_cont_left = 2'd2;
              u8_cp        = {17'd0, b[3:0]};
              u8_class     = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
              u8_cont_left = 2'd3;
              u8_cp        = {18'd0, b[2:0]};
              u8_class     = 2'd3;
            end else begin
              u8_bad = 1'b1;
            end
          end
        end else if (b[7:6] != 2'b10) begin
          u8_bad       = 1'b1;
          u8_cont_left = 2'd0;
        end else begin
          u8_cp        = {u8_cp[14:0], b[5:0]};
          u8_cont_left = u8_cont_left - 2'd1;
          if (u8_cont_left == 2'd0) begin
            least = (u8_class == 2'd1) ? 21'h80 : (u8_class == 2'd2) ? 21'h800 : 21'h10000;
            if (u8_cp < least || u8_cp > 21'h10FFFF || (u8_cp >= 21'hD800 && u8_cp <= 21'hDFFF))
              u8_bad = 1'b1;
          end
        end
      end

      // Bracket nesting outside of strings; the level saturates past the limit.
      if (str_open) begin
        if (str_escape) str_escape = 1'b0;
        else if (b == CH_BSLASH) str_escape = 1'b1;
        else if (b == CH_QUOTE) str_open = 1'b0;
      end else if (b == CH_QUOTE) begin
        str_open = 1'b1;
      end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
        if (nest <= {1'b0, depth_limit}) nest = nest + 9'd1;
        if (nest > {1'b0, depth_limit}) nest_over = 1'b1;
      end else if ((b == CH_RBRACE || b == CH_RBRACKET) && nest != 9'd0) begin
        nest = nest - 9'd1;
      end
    end

    // Verdict in priority order, then the line state starts over.
    if (eol) begin
      if (!seen_byte) v = VERDICT_EMPTY;
      else if (bom_pos == 2'd3 && bom_ok) v = VERDICT_BOM;
      else if (u8_bad || u8_cont_left != 2'd0) v = VERDICT_BAD_UTF8;
      else if (nest_over) v = VERDICT_TOO_DEEP;
      else v = VERDICT_OK;
      verdicts_due = {verdicts_due, v};
      clear_line_state();
    end
  endtask

  // Each verdict taken from the block is compared with the oldest expected one.
  always @(posedge clk_i) begin : verdict_check
    verdict_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("verdict %0d with no line end pending", verdict_o));
      end else begin
        want = verdicts_due.pop_front();
        if (verdict_o !== want)
          report_mismatch($sformatf("verdict %0d, expected %0d", verdict_o, want));
      end
    end
  end

  // Output stall comes in random bursts, none once the flow is steady.
  always begin
    @(negedge clk_i);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      out_stall_i = 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
      out_stall_i = 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
    end
  end

  // Sends one item, with an optional idle burst ahead of it. Called and
  // returns at a falling edge; valid stays high for a following item.
  task automatic send_item(input logic [7:0] b, input logic pres, input logic eol);
    if (!steady_flow && $urandom_range(0, 7) == 0) begin
      in_valid_i  = 1'b0;
      data_byte_i = 8'($urandom);
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    data_byte_i    = b;
    byte_present_i = pres;
    end_of_line_i  = eol;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_verdict(b, pres, eol);
    items_taken++;
    @(negedge clk_i);
  endtask

  // Sends a line. In loose mode, ignored items are scattered in and the line
  // may end with an item that carries no byte.
  task automatic send_line(input line_t q, input bit loose);
    bit absent_end;
    absent_end = loose && ($urandom_range(0, 7) == 0);
    if (q.size() == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1);
    end else begin
      foreach (q[i]) begin
        if (loose && $urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(q[i], 1'b1, (i == q.size() - 1) && !absent_end);
      end
      if (absent_end) send_item(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic wait_for_verdicts();
    in_valid_i = 1'b0;
    wait (verdicts_due.size() == 0);
    @(negedge clk_i);
  endtask

  // One APB transfer to the nesting limit register.
  task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {REG_MAX_DEPTH, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    if (wr) depth_limit = wdata[7:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_depth_limit();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[7:0] !== depth_limit)
      report_mismatch($sformatf("nesting limit reads %0d, expected %0d", rd[7:0], depth_limit));
  endtask

  // The limit is changed only with no line open and no verdict in flight.
  task automatic set_depth_limit(input logic [7:0] lim);
    logic [DATA_W-1:0] rd;
    wait_for_verdicts();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    apb_access(1'b1, {24'($urandom), lim}, rd);
    check_depth_limit();
  endtask

  // Appends one byte to the end of a line.
  task automatic append_byte(ref line_t q, input logic [7:0] b);
    q = {q, b};
  endtask

  task automatic push_code_point(ref line_t q, input int n, input logic [20:0] cp);
    case (n)
      1: append_byte(q, {1'b0, cp[6:0]});
      2: begin
        append_byte(q, {3'b110, cp[10:6]});
        append_byte(q, {2'b10, cp[5:0]});
      end
      3: begin
        append_byte(q, {4'b1110, cp[15:12]});
        append_byte(q, {2'b10, cp[11:6]});
        append_byte(q, {2'b10, cp[5:0]});
      end
      default: begin
        append_byte(q, {5'b11110, cp[20:18]});
        append_byte(q, {2'b10, cp[17:12]});
        append_byte(q, {2'b10, cp[11:6]});
        append_byte(q, {2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Appends one encoded character, valid or broken in one of several ways.
  task automatic add_utf8_char(ref line_t q, input bit corrupt);
    int          n;
    logic [20:0] cp;
    logic [20:0] lo;
    logic [20:0] hi;
    logic [7:0]  b;
    int unsigned pos;
    n = $urandom_range(1, 4);
    case (n)
      1:       begin lo = 21'h0;     hi = 21'h7F;     end
      2:       begin lo = 21'h80;    hi = 21'h7FF;    end
      3:       begin lo = 21'h800;   hi = 21'hFFFF;   end
      default: begin lo = 21'h10000; hi = 21'h10FFFF; end
    endcase
    if ($urandom_range(0, 3) == 0) cp = $urandom_range(0, 1) ? hi : lo;
    else cp = 21'($urandom_range(lo, hi));
    if (n == 3 && cp >= 21'hD800 && cp <= 21'hDFFF) cp = 21'hE000;
    if (!corrupt) begin
      push_code_point(q, n, cp);
    end else begin
      case ($urandom_range(0, 5))
        // Overlong form.
        0: begin
          n  = $urandom_range(2, 4);
          cp = 21'($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF));
          push_code_point(q, n, cp);
        end
        // Surrogate.
        1: push_code_point(q, 3, 21'($urandom_range('hD800, 'hDFFF)));
        // Above the last code point.
        2: push_code_point(q, 4, 21'($urandom_range('h110000, 'h1FFFFF)));
        // Bad lead byte.
        3: append_byte(q, $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                               : 8'($urandom_range('hF8, 'hFF)));
        // Sequence cut short.
        4: begin
          n = $urandom_range(2, 4);
          push_code_point(q, n, cp);
          repeat ($urandom_range(1, n - 1)) q.delete(q.size() - 1);
        end
        // Continuation byte replaced by something else.
        default: begin
          n = $urandom_range(2, 4);
          push_code_point(q, n, cp);
          pos = q.size() - $urandom_range(1, n - 1);
          b   = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          q[pos] = b;
        end
      endcase
    end
  endtask

  // Appends a string that may hold brackets, escapes and multibyte text,
  // and is now and then left open.
  task automatic add_string(ref line_t q);
    append_byte(q, CH_QUOTE);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0: append_byte(q, 8'($urandom_range('h61, 'h7A)));
        1: append_byte(q, $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
        2: begin
          append_byte(q, CH_BSLASH);
          case ($urandom_range(0, 2))
            0:       append_byte(q, CH_QUOTE);
            1:       append_byte(q, CH_BSLASH);
            default: append_byte(q, 8'($urandom_range(32, 126)));
          endcase
        end
        3: add_utf8_char(q, 1'b0);
        4: append_byte(q, $urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
        default: append_byte(q, 8'($urandom_range(32, 126)));
      endcase
    end
    if ($urandom_range(0, 7) != 0) append_byte(q, CH_QUOTE);
  endtask

  // Appends a bracket structure. Deep ones reach the limit or one past it.
  task automatic add_json(ref line_t q, input bit deep);
    int unsigned opens;
    int unsigned closes;
    if (deep) opens = depth_limit + $urandom_range(0, 1);
    else if (depth_limit <= 8) opens = $urandom_range(0, depth_limit + 2);
    else opens = $urandom_range(0, 4);
    if (deep) closes = $urandom_range(0, 2);
    else if ($urandom_range(0, 3) == 0) closes = opens + $urandom_range(0, 2);
    else closes = opens;
    if ($urandom_range(0, 5) == 0)
      append_byte(q, $urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
    repeat (opens) begin
      append_byte(q, $urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
      if (!deep && $urandom_range(0, 3) == 0) add_string(q);
      if (!deep && $urandom_range(0, 5) == 0) begin
        append_byte(q, CH_LBRACKET);
        append_byte(q, CH_RBRACKET);
      end
    end
    if ($urandom_range(0, 1) == 0) add_string(q);
    else append_byte(q, 8'($urandom_range('h30, 'h39)));
    repeat (closes) append_byte(q, $urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
  endtask

  // Builds one random line. Most are well formed with random content, the
  // rest are broken text, byte order marks, noise or empty lines.
  task automatic gen_line(ref line_t q);
    int unsigned n;
    q.delete();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_json(q, depth_limit > 8 && $urandom_range(0, 24) == 0);
      4, 5: repeat ($urandom_range(1, 6)) add_utf8_char(q, $urandom_range(0, 4) == 0);
      6: begin
        n = $urandom_range(1, 3);
        append_byte(q, BOM_0);
        if (n > 1) append_byte(q, BOM_1);
        if (n > 2) append_byte(q, BOM_2);
        case ($urandom_range(0, 2))
          0:       add_json(q, 1'b0);
          1:       add_utf8_char(q, $urandom_range(0, 3) == 0);
          default: ;
        endcase
      end
      7: repeat ($urandom_range(1, 8)) append_byte(q, 8'($urandom));
      8: begin
        add_json(q, 1'b0);
        add_utf8_char(q, 1'b1);
      end
      default: ;
    endcase
    if (q.size() > 0 && $urandom_range(0, 9) == 0)
      q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
  endtask

  // Empty lines, ignored items, lines ending without a byte, byte order marks.
  task automatic test_line_framing();
    check_depth_limit();
    send_item(8'hA5, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h78, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_line('{BOM_0, BOM_1, BOM_2}, 1'b0);
    send_line('{BOM_0, BOM_1}, 1'b0);
  endtask

  // Bad lead, overlong, surrogate, out of range and bad continuation.
  task automatic test_utf8_rules();
    send_line('{8'h80}, 1'b0);
    send_line('{8'hC1, 8'hBF}, 1'b0);
    send_line('{8'hED, 8'hA0, 8'h80}, 1'b0);
    send_line('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);
    send_line('{8'hC3, 8'h28}, 1'b0);
  endtask

  // Closing bracket at depth zero, limit overrun, brackets hidden in a string.
  task automatic test_nesting_rules();
    set_depth_limit(8'd1);
    send_line('{CH_RBRACKET, CH_LBRACKET, CH_LBRACE}, 1'b0);
    send_line('{CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_LBRACKET, CH_LBRACKET}, 1'b0);
  endtask

  // Random lines under one nesting limit. A large limit starts with one line
  // that reaches it.
  task automatic test_random_traffic(input logic [7:0] lim, input bit write_lim,
                                     input bit hold_midway, input int unsigned n_items);
    line_t       q;
    int unsigned stop_at;
    bit          held;
    if (write_lim) set_depth_limit(lim);
    stop_at = items_taken + n_items;
    held    = 1'b0;
    if (depth_limit > 8) begin
      q.delete();
      add_json(q, 1'b1);
      send_line(q, 1'b1);
    end
    while (items_taken < stop_at) begin
      gen_line(q);
      send_line(q, 1'b1);
      // Let the pipeline run dry once, mid-phase.
      if (hold_midway && !held && items_taken >= stop_at - n_items / 2) begin
        wait_for_verdicts();
        held = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    byte_present_i = 1'b0;
    end_of_line_i  = 1'b0;
    items_taken    = 0;
    mismatch_count = 0;
    steady_flow    = 1'b0;
    depth_limit    = MAX_DEPTH_RESET;
    clear_line_state();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_line_framing();
    test_utf8_rules();
    test_nesting_rules();
    test_random_traffic(depth_limit, 1'b0, 1'b1, PHASE_ITEMS);
    test_random_traffic(8'd0, 1'b1, 1'b0, PHASE_ITEMS);
    test_random_traffic(8'd255, 1'b1, 1'b0, PHASE_ITEMS);
    test_random_traffic(8'd64, 1'b1, 1'b0, PHASE_ITEMS);
    test_random_traffic(8'($urandom_range(2, 254)), 1'b1, 1'b0, PHASE_ITEMS);
    steady_flow = 1'b1;
    test_random_traffic(8'($urandom_range(2, 8)), 1'b1, 1'b0, PHASE_ITEMS);

    // Drain, then give any stray verdict a chance to show up.
    wait_for_verdicts();
    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
